// ===== hdl/fids_pkg.sv =====
// package for the firmware id stream scanner
// scan phases, queue entry type, signature constants and byte classifiers
`timescale 1ns / 1ps
package fids_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 4;
	localparam logic [7:0] CAP_RESET = 8'd63;

	localparam logic [47:0] SIG_A = 48'h707267435843;
	localparam logic [47:0] SIG_B = 48'h707267313230;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;

	// value of byte address bit 2 that selects the id_capacity register
	localparam logic REG_ID_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_COPY1  = 3'd1,
		PH_SKIPZ  = 3'd2,
		PH_COPY2  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// one queued job: up to six characters then an optional status item
	typedef struct packed {
		logic [5:0][7:0] chars;    // chars[5] goes out first
		logic [2:0]      n_chars;
		logic            status;
		logic            found;
		logic [7:0]      length;
	} job_t;

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

// ===== hdl/fids_front.sv =====
// front part: window match, phase tracking and job building per input item
// depends on fids_pkg
`timescale 1ns / 1ps
module fids_front import fids_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [7:0] id_capacity,
	output logic       job_push,
	output job_t       job
);

	phase_t      phase_q, phase_d;
	logic [39:0] window_q, window_d;
	logic [2:0]  fill_q, fill_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        seen_q, seen_d;

	logic [47:0] six;
	logic        match;
	logic [7:0]  avail;

	assign six   = {window_q, data_byte};
	assign match = (fill_q >= 3'd5) && ((six == SIG_A) || (six == SIG_B));
	assign avail = (cnt_q >= id_capacity) ? 8'd0 : (id_capacity - cnt_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (match) begin
					phase_d = (avail <= 8'd6) ? PH_DONE : PH_COPY1;
				end
			end
			PH_COPY1: begin
				if (is_term(data_byte)) begin
					phase_d = (data_byte == CH_NUL) ? PH_SKIPZ : PH_DONE;
				end else if (avail <= 8'd1) begin
					phase_d = PH_DONE;
				end
			end
			PH_SKIPZ: begin
				if (data_byte != CH_NUL) begin
					phase_d = (is_alnum(data_byte) && avail >= 8'd3) ? PH_COPY2 : PH_DONE;
				end
			end
			PH_COPY2: begin
				if (is_term(data_byte) || avail <= 8'd1) begin
					phase_d = PH_DONE;
				end
			end
			default: phase_d = phase_q;
		endcase
		if (last_byte) begin
			phase_d = PH_SEARCH;
		end
	end

	// datapath and job
	always_comb begin
		logic [2:0] n;
		logic [5:0][7:0] ch;
		logic [7:0] cnt_new;
		logic seen_new;
		n        = 3'd0;
		ch       = '0;
		window_d = window_q;
		fill_d   = fill_q;
		seen_new = seen_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (match) begin
					seen_new = 1'b1;
					n        = (avail >= 8'd6) ? 3'd6 : avail[2:0];
					ch       = six;
				end else begin
					window_d = six[39:0];
					if (fill_q < 3'd5) begin
						fill_d = fill_q + 3'd1;
					end
				end
			end
			PH_COPY1, PH_COPY2: begin
				if (!is_term(data_byte) && avail != 8'd0) begin
					n     = 3'd1;
					ch[5] = data_byte;
				end
			end
			PH_SKIPZ: begin
				if (data_byte != CH_NUL && is_alnum(data_byte)) begin
					n     = (avail >= 8'd2) ? 3'd2 : avail[2:0];
					ch[5] = CH_UNDERSCORE;
					ch[4] = data_byte;
				end
			end
			default: n = 3'd0;
		endcase
		cnt_new = cnt_q + {5'd0, n};

		job.chars   = ch;
		job.n_chars = n;
		job.status  = last_byte;
		job.found   = seen_new;
		job.length  = cnt_new;
		job_push    = accept && ((n != 3'd0) || last_byte);

		cnt_d  = cnt_new;
		seen_d = seen_new;
		if (last_byte) begin
			window_d = '0;
			fill_d   = 3'd0;
			cnt_d    = 8'd0;
			seen_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			window_q <= '0;
			fill_q   <= 3'd0;
			cnt_q    <= 8'd0;
			seen_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			cnt_q    <= cnt_d;
			seen_q   <= seen_d;
		end
	end

endmodule

// ===== hdl/fids_fifo.sv =====
// short job queue between the front and back parts, flop based
// depends on fids_pkg
`timescale 1ns / 1ps
module fids_fifo import fids_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/fids_back.sv =====
// back part: walks the head job and hands out one result item per pop
// depends on fids_pkg
`timescale 1ns / 1ps
module fids_back import fids_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       head_empty,
	output logic       head_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       is_status,
	output logic       id_found,
	output logic [7:0] id_length,
	output logic       last_result
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_char;
	logic       final_one;
	logic       take;

	assign empty     = head_empty;
	assign total     = head.n_chars + {2'd0, head.status};
	assign final_one = (idx_q == total - 3'd1);
	assign is_char   = (idx_q < head.n_chars);
	assign take      = pop && !head_empty;
	assign head_pop  = take && final_one;

	always_comb begin
		out_char = 8'd0;
		if (is_char) begin
			case (idx_q)
				3'd0:    out_char = head.chars[5];
				3'd1:    out_char = head.chars[4];
				3'd2:    out_char = head.chars[3];
				3'd3:    out_char = head.chars[2];
				3'd4:    out_char = head.chars[1];
				3'd5:    out_char = head.chars[0];
				default: out_char = 8'd0;
			endcase
		end
	end

	assign is_status   = !is_char;
	assign id_found    = is_char ? 1'b0 : head.found;
	assign id_length   = is_char ? 8'd0 : head.length;
	assign last_result = final_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= final_one ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// ===== hdl/firmware_id_stream_scanner.sv =====
// top level of the firmware id stream scanner
// depends on fids_pkg, fids_front, fids_fifo, fids_back
// path: an item's results pass through the job queue registers before the result ports
// throughput: one input item per cycle while the job queue has room; one result per cycle
// out while pop is high and results wait; a matching item yields up to seven results
// reset: arst_n clears scan state, queue and id_capacity (back to 63) at once
`timescale 1ns / 1ps
module firmware_id_stream_scanner import fids_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	// result items
	output logic [7:0]  out_char,
	output logic        is_status,
	output logic        id_found,
	output logic [7:0]  id_length,
	output logic        last_result,
	output logic        empty,
	input  logic        pop
);

	logic [7:0] cap_q;
	logic       in_accept;
	logic       job_push;
	job_t       job_in;
	job_t       job_head;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;

	// register file: one register, id_capacity, at byte addresses 0 to 3 (paddr[2] low)
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ID_CAPACITY) ? {24'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ID_CAPACITY) begin
			cap_q <= pwdata[7:0];
		end
	end

	// an item is taken whenever the queue has room for its job, even if
	// it turns out to produce nothing
	assign full      = q_full;
	assign in_accept = push && !q_full;

	// front: window compare, phase tracking, job building
	fids_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.id_capacity (cap_q),
		.job_push    (job_push),
		.job         (job_in)
	);

	// decouples the two sides: front keeps taking bytes while the back
	// drains a multi-item job
	fids_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_job (job_head),
		.empty  (q_empty)
	);

	// back: one result item per pop from the head job
	fids_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (job_head),
		.head_empty  (q_empty),
		.head_pop    (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_char    (out_char),
		.is_status   (is_status),
		.id_found    (id_found),
		.id_length   (id_length),
		.last_result (last_result)
	);

endmodule
